FILE: rtl/crpr_pkg.sv
// ----------------------------------------------------------------------------
// Primary weight reorder package
// Operation and register codes, fixed masks and the request and response
// bundles between the sequencer and the range scanner.
// ----------------------------------------------------------------------------
package crpr_pkg;

  localparam int unsigned RANGE_DEPTH_DEFAULT = 32;

  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned BYTE_W   = 8;

  localparam logic [1:0] OP_QUERY       = 2'd0;
  localparam logic [1:0] OP_WRITE_LEAD  = 2'd1;
  localparam logic [1:0] OP_WRITE_RANGE = 2'd2;
  localparam logic [1:0] OP_NONE        = 2'd3;

  localparam logic [1:0] CFG_HIGH_LIMIT = 2'd0;
  localparam logic [1:0] CFG_RANGE_CNT  = 2'd1;
  localparam logic [1:0] CFG_NO_CE      = 2'd2;
  localparam logic [1:0] CFG_SPARE      = 2'd3;

  localparam logic [WEIGHT_W-1:0] LOW16_FILL = 32'h0000_FFFF;

  typedef struct packed {
    logic                start;
    logic [WEIGHT_W-1:0] weight;
    logic [COUNT_W-1:0]  count;
    logic                wr_en;
    logic [INDEX_W-1:0]  wr_addr;
    logic [WEIGHT_W-1:0] wr_data;
  } scan_req_t;

  typedef struct packed {
    logic                done;
    logic [WEIGHT_W-1:0] weight;
    logic                miss;
  } scan_rsp_t;

endpackage

FILE: rtl/crpr_range_scan.sv
// ----------------------------------------------------------------------------
// Range scanner
// Holds the range store and walks it one word at a time with a single
// comparator, returning the offset weight of the first limit above q.
// ----------------------------------------------------------------------------
module crpr_range_scan import crpr_pkg::*; #(
  parameter int unsigned RANGE_DEPTH = RANGE_DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_req_t req_i,
  output scan_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(RANGE_DEPTH + 1);
  localparam int unsigned IdxW = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
  localparam int unsigned ExtW = (CntW > COUNT_W) ? CntW : COUNT_W;

  localparam logic [1:0] SC_IDLE = 2'd0;
  localparam logic [1:0] SC_READ = 2'd1;
  localparam logic [1:0] SC_CMP  = 2'd2;

  logic [WEIGHT_W-1:0] range_mem_q [RANGE_DEPTH];
  logic [WEIGHT_W-1:0] rd_q;

  logic [1:0]          state_q;
  logic [CntW-1:0]     idx_q;
  logic [CntW-1:0]     lim_q;
  logic [CntW-1:0]     lim_d;
  logic [CntW-1:0]     idx_nxt;
  logic [WEIGHT_W-1:0] p_q;
  logic [WEIGHT_W-1:0] q_q;
  logic                done_q;
  logic                miss_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [ExtW-1:0]     count_ext;
  logic                wr_in_range;
  logic                hit;
  logic [BYTE_W-1:0]   lead_sum;

  assign count_ext   = ExtW'(req_i.count);
  assign lim_d       = (count_ext > ExtW'(RANGE_DEPTH)) ? CntW'(RANGE_DEPTH)
                                                        : CntW'(count_ext);
  assign idx_nxt     = idx_q + CntW'(1);
  assign wr_in_range = ({1'b0, req_i.wr_addr} < (INDEX_W + 1)'(RANGE_DEPTH));
  assign hit         = (q_q < rd_q);
  assign lead_sum    = p_q[WEIGHT_W-1 -: BYTE_W] + rd_q[BYTE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && wr_in_range) begin
      range_mem_q[req_i.wr_addr[IdxW-1:0]] <= req_i.wr_data;
    end
    rd_q <= range_mem_q[idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      done_q  <= 1'b0;
      idx_q   <= '0;
      lim_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        SC_IDLE: begin
          if (req_i.start) begin
            idx_q <= '0;
            lim_q <= lim_d;
            if (lim_d == '0) begin
              done_q <= 1'b1;
            end else begin
              state_q <= SC_READ;
            end
          end
        end
        SC_READ: begin
          state_q <= SC_CMP;
        end
        SC_CMP: begin
          if (hit || (idx_nxt == lim_q)) begin
            done_q  <= 1'b1;
            state_q <= SC_IDLE;
          end else begin
            idx_q   <= idx_nxt;
            state_q <= SC_READ;
          end
        end
        default: begin
          state_q <= SC_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SC_IDLE && req_i.start) begin
      p_q      <= req_i.weight;
      q_q      <= req_i.weight | LOW16_FILL;
      weight_q <= req_i.weight;
      miss_q   <= 1'b1;
    end else if (state_q == SC_CMP && hit) begin
      weight_q <= {lead_sum, p_q[WEIGHT_W-BYTE_W-1:0]};
      miss_q   <= 1'b0;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.weight = weight_q;
  assign rsp_o.miss   = miss_q;

endmodule

FILE: rtl/collation_primary_reorder_top.sv
// ----------------------------------------------------------------------------
// Primary collation weight reorder
// Remaps 32-bit primary weights through a lead-byte table and a scanned
// store of split-range words.
// ----------------------------------------------------------------------------
// One beat is taken at a time. A table write, a range write or an unused
// operation goes straight to the done state with a zero result; a query
// first passes the lead-byte lookup state, and one settled by the lead-byte
// table, the no-CE limit or the high limit then goes to the done state; a
// query on a split lead byte enters the scan state, where the single
// comparator walks the range store one registered read at a time. A finished
// result waits in the output register while the next beat is taken.
module collation_primary_reorder_top import crpr_pkg::*; #(
  parameter int unsigned RANGE_DEPTH = RANGE_DEPTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [WEIGHT_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic [WEIGHT_W-1:0] primary_weight_i,
  input  logic [INDEX_W-1:0]  entry_index_i,
  input  logic [BYTE_W-1:0]   lead_byte_value_i,
  input  logic [WEIGHT_W-1:0] range_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [WEIGHT_W-1:0] reordered_weight_o,
  output logic                range_missing_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LEAD = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [WEIGHT_W-1:0] high_limit_q;
  logic [COUNT_W-1:0]  range_count_q;
  logic [WEIGHT_W-1:0] no_ce_limit_q;

  logic [BYTE_W-1:0]   lead_mem_q [256];
  logic [BYTE_W-1:0]   lead_rd_q;

  logic [1:0]          state_q;
  logic [1:0]          state_d;
  logic [WEIGHT_W-1:0] p_q;
  logic [WEIGHT_W-1:0] res_q;
  logic                res_miss_q;
  logic                out_valid_q;
  logic                out_valid_d;
  logic [WEIGHT_W-1:0] out_weight_q;
  logic                out_miss_q;

  logic                in_beat;
  logic                lead_hit;
  logic                pass_high;
  logic                out_load;
  scan_req_t           scan_req;
  scan_rsp_t           scan_rsp;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign lead_hit   = (lead_rd_q != '0) || (p_q <= no_ce_limit_q);
  assign pass_high  = (p_q >= high_limit_q);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_limit_q  <= '0;
      range_count_q <= '0;
      no_ce_limit_q <= WEIGHT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HIGH_LIMIT: high_limit_q  <= cfg_wdata_i;
        CFG_RANGE_CNT:  range_count_q <= cfg_wdata_i[COUNT_W-1:0];
        CFG_NO_CE:      no_ce_limit_q <= cfg_wdata_i;
        CFG_SPARE:      ;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat && operation_i == OP_WRITE_LEAD) begin
      lead_mem_q[entry_index_i] <= lead_byte_value_i;
    end
    if (in_beat) begin
      lead_rd_q <= lead_mem_q[primary_weight_i[WEIGHT_W-1 -: BYTE_W]];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d = (operation_i == OP_QUERY) ? ST_LEAD : ST_DONE;
        end
      end
      ST_LEAD: begin
        state_d = (lead_hit || pass_high) ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      p_q        <= primary_weight_i;
      res_q      <= '0;
      res_miss_q <= 1'b0;
    end else if (state_q == ST_LEAD) begin
      if (lead_hit) begin
        res_q <= {lead_rd_q, p_q[WEIGHT_W-BYTE_W-1:0]};
      end else begin
        res_q <= p_q;
      end
      res_miss_q <= 1'b0;
    end else if (state_q == ST_SCAN && scan_rsp.done) begin
      res_q      <= scan_rsp.weight;
      res_miss_q <= scan_rsp.miss;
    end
    if (out_load) begin
      out_weight_q <= res_q;
      out_miss_q   <= res_miss_q;
    end
  end

  assign scan_req.start   = (state_q == ST_LEAD) && !lead_hit && !pass_high;
  assign scan_req.weight  = p_q;
  assign scan_req.count   = range_count_q;
  assign scan_req.wr_en   = in_beat && (operation_i == OP_WRITE_RANGE);
  assign scan_req.wr_addr = entry_index_i;
  assign scan_req.wr_data = range_word_i;

  crpr_range_scan #(
    .RANGE_DEPTH(RANGE_DEPTH)
  ) u_range_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (scan_req),
    .rsp_o (scan_rsp)
  );

  assign out_valid_o        = out_valid_q;
  assign reordered_weight_o = out_weight_q;
  assign range_missing_o    = out_miss_q;

`ifndef SYNTHESIS
  a_scan_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_rsp.done |-> (state_q == ST_SCAN))
    else $error("range scan finished outside the scan state");

  a_beat_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == ST_LEAD || state_q == ST_DONE))
    else $error("accepted beat did not start work");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished result not moved to the output register");

  a_start_from_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_req.start |=> (state_q == ST_SCAN))
    else $error("scan started without entering the scan state");
`endif

endmodule
